@@ rtl/rsa_modexp_with_counter_whitening_core_defines.svh @@
// assertion macros for the modular exponentiation core
`ifndef RSA_MODEXP_WITH_COUNTER_WHITENING_CORE_DEFINES_SVH
`define RSA_MODEXP_WITH_COUNTER_WHITENING_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rme_pkg.sv @@
// shared types and constants of the modular exponentiation core
package rme_pkg;

  localparam int WIDTH     = 64;
  localparam int CNT_W     = $clog2(WIDTH + 1);
  localparam int MM_SUM_W  = WIDTH + 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS    = 2'd0,
    CFG_PUB_EXP    = 2'd1,
    CFG_PRIV_EXP   = 2'd2,
    CFG_WHITEN_KEY = 2'd3
  } cfg_reg_t;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

@@ rtl/rme_in_if.sv @@
// input channel: action, message start flag and data chunk
interface rme_in_if import rme_pkg::*;;
  logic             valid;
  logic             ready;
  logic             action;
  logic             start_message;
  logic [WIDTH-1:0] data_word;

  modport source (output valid, action, start_message, data_word, input ready);
  modport sink (input valid, action, start_message, data_word, output ready);
endinterface

@@ rtl/rme_out_if.sv @@
// output channel: result chunk
interface rme_out_if import rme_pkg::*;;
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result_word;

  modport source (output valid, result_word, input ready);
  modport sink (input valid, result_word, output ready);
endinterface

@@ rtl/rme_modmul.sv @@
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module rme_modmul import rme_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] n,
  output mm_status_t       status,
  output logic [WIDTH-1:0] result
);

  logic [WIDTH-1:0]    a_sh;
  logic [WIDTH-1:0]    b_reg;
  logic [WIDTH-1:0]    r;
  logic [WIDTH-1:0]    r_next;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  logic [MM_SUM_W-1:0] sum;
  logic [MM_SUM_W-1:0] diff1;
  logic [MM_SUM_W-1:0] diff2;

  // r stays below n, so 2r + b stays below 3n
  always_comb begin
    sum   = {2'b00, r, 1'b0} + (a_sh[WIDTH-1] ? {3'b000, b_reg} : '0);
    diff1 = sum - {3'b000, n};
    diff2 = sum - {2'b00, n, 1'b0};
    if (n == '0) begin
      r_next = sum[WIDTH-1:0];
    end else if (!diff2[MM_SUM_W-1]) begin
      r_next = diff2[WIDTH-1:0];
    end else if (!diff1[MM_SUM_W-1]) begin
      r_next = diff1[WIDTH-1:0];
    end else begin
      r_next = sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        a_sh  <= a;
        b_reg <= b;
        r     <= '0;
        cnt   <= CNT_W'(WIDTH);
        busy  <= 1'b1;
      end else if (busy) begin
        r    <= r_next;
        a_sh <= {a_sh[WIDTH-2:0], 1'b0};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign result      = r;

endmodule

@@ rtl/rsa_modexp_with_counter_whitening_core.sv @@
// modular exponentiation core with counter whitening, top level
//
// Configuration is written through cfg_we / cfg_index / cfg_data: modulus,
// public exponent, private exponent, whitening key. The user must write it
// only while the core is idle; the core does not enforce this. Each
// transaction on in_ch carries a chunk and an action. Encrypt returns
// (chunk^e mod n) xor counter, decrypt returns (chunk xor counter)^d mod n.
// A start_message flag reloads the counter from the whitening key first; the
// counter steps by one after every chunk. One shared bit-serial modular
// multiplier does all the work, one bit per cycle. A chunk costs one
// reduction of the base, one scan step per leading zero of the exponent plus
// one, and for each bit from the top set bit down a square plus, on a set
// bit, a multiply, and a final step to hand off the result. in_ch.ready is
// high only while no chunk is in work. The result sits in an output
// register; a new chunk is taken while it waits, and a finished chunk holds
// until the register is free. Reset clears the configuration registers, the
// state, the counter and the output valid.
`include "rsa_modexp_with_counter_whitening_core_defines.svh"

module rsa_modexp_with_counter_whitening_core import rme_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH-1:0]     cfg_data,
  rme_in_if.sink               in_ch,
  rme_out_if.source            out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE_WAIT,
    S_SCAN,
    S_SQ_START,
    S_SQ_WAIT,
    S_MUL_START,
    S_MUL_WAIT,
    S_FINISH
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] public_exponent;
  logic [WIDTH-1:0] private_exponent;
  logic [WIDTH-1:0] whitening_key;
  logic [WIDTH-1:0] xor_counter;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] exp_sh;
  logic [CNT_W-1:0] bit_cnt;
  logic             decrypting;
  logic [WIDTH-1:0] result_word;
  logic             res_valid;

  logic             in_accept;
  logic             out_free;
  logic [WIDTH-1:0] ctr_eff;
  logic [WIDTH-1:0] base_in;
  logic             mm_start;
  logic [WIDTH-1:0] mm_a;
  logic [WIDTH-1:0] mm_b;
  logic [WIDTH-1:0] mm_res;
  mm_status_t       mm_status;

  assign in_ch.ready        = (state == S_IDLE);
  assign in_accept          = in_ch.valid && in_ch.ready;
  assign out_free           = !res_valid || out_ch.ready;
  assign out_ch.valid       = res_valid;
  assign out_ch.result_word = result_word;

  assign ctr_eff = in_ch.start_message ? whitening_key : xor_counter;
  assign base_in = (in_ch.action == ACT_DECRYPT) ? (in_ch.data_word ^ ctr_eff)
                                                 : in_ch.data_word;

  always_comb begin
    mm_start = 1'b0;
    mm_a     = '0;
    mm_b     = '0;
    unique case (state)
      S_IDLE: begin
        mm_start = in_accept;
        mm_a     = base_in;
        mm_b     = WIDTH'(1);
      end
      S_SQ_START: begin
        mm_start = 1'b1;
        mm_a     = acc;
        mm_b     = acc;
      end
      S_MUL_START: begin
        mm_start = 1'b1;
        mm_a     = acc;
        mm_b     = base;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  rme_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .n      (modulus),
    .status (mm_status),
    .result (mm_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= '0;
      public_exponent  <= '0;
      private_exponent <= '0;
      whitening_key    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MODULUS:    modulus          <= cfg_data;
        CFG_PUB_EXP:    public_exponent  <= cfg_data;
        CFG_PRIV_EXP:   private_exponent <= cfg_data;
        CFG_WHITEN_KEY: whitening_key    <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      xor_counter <= '0;
      res_valid   <= 1'b0;
      bit_cnt     <= '0;
      decrypting  <= 1'b0;
    end else begin
      if (res_valid && out_ch.ready && !((state == S_FINISH) && out_free)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            xor_counter <= ctr_eff;
            decrypting  <= in_ch.action;
            exp_sh      <= (in_ch.action == ACT_DECRYPT) ? private_exponent
                                                         : public_exponent;
            bit_cnt     <= CNT_W'(WIDTH);
            state       <= S_REDUCE_WAIT;
          end
        end
        S_REDUCE_WAIT: begin
          if (mm_status.done) begin
            base  <= mm_res;
            acc   <= WIDTH'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (bit_cnt == '0) begin
            state <= S_FINISH;
          end else if (exp_sh[WIDTH-1]) begin
            state <= S_SQ_START;
          end else begin
            exp_sh  <= {exp_sh[WIDTH-2:0], 1'b0};
            bit_cnt <= bit_cnt - CNT_W'(1);
          end
        end
        S_SQ_START: begin
          state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (mm_status.done) begin
            acc <= mm_res;
            if (exp_sh[WIDTH-1]) begin
              state <= S_MUL_START;
            end else begin
              exp_sh  <= {exp_sh[WIDTH-2:0], 1'b0};
              bit_cnt <= bit_cnt - CNT_W'(1);
              state   <= (bit_cnt == CNT_W'(1)) ? S_FINISH : S_SQ_START;
            end
          end
        end
        S_MUL_START: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mm_status.done) begin
            acc     <= mm_res;
            exp_sh  <= {exp_sh[WIDTH-2:0], 1'b0};
            bit_cnt <= bit_cnt - CNT_W'(1);
            state   <= (bit_cnt == CNT_W'(1)) ? S_FINISH : S_SQ_START;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            result_word <= (decrypting == ACT_DECRYPT) ? acc : (acc ^ xor_counter);
            res_valid   <= 1'b1;
            xor_counter <= xor_counter + WIDTH'(1);
            state       <= S_IDLE;
          end
        end
      endcase
    end
  end

  `RME_ASSERT_IMP(a_idle_unit_free, in_ch.ready, !mm_status.busy, "input ready while multiplier busy")
  `RME_ASSERT_IMP(a_done_in_wait, mm_status.done, (state == S_REDUCE_WAIT) || (state == S_SQ_WAIT) || (state == S_MUL_WAIT), "multiplier done outside a wait state")
  `RME_ASSERT_NXT(a_accept_starts, in_accept, (state == S_REDUCE_WAIT) && mm_status.busy, "accepted transaction did not start reduction")
  `RME_ASSERT_NXT(a_counter_steps, (state == S_FINISH) && out_free, out_ch.valid && (xor_counter == $past(xor_counter) + WIDTH'(1)), "counter did not step with result")

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the modular exponentiation core with counter whitening
module tb;
  import rme_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int END_WAIT    = 9000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIDTH-1:0]     cfg_data;

  rme_in_if  in_ch();
  rme_out_if out_ch();

  rsa_modexp_with_counter_whitening_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  logic [WIDTH-1:0] mod_n;
  logic [WIDTH-1:0] exp_pub;
  logic [WIDTH-1:0] exp_priv;
  logic [WIDTH-1:0] whiten_key;
  logic [WIDTH-1:0] whiten_ctr;

  logic [WIDTH-1:0] pending_results[$];
  int               err_cnt;
  int               cycle_cnt;
  bit               tx_gaps_on;
  bit               rx_stalls_on;
  int               rx_hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [WIDTH-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WIDTH-1:0] mul_reduce(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b,
                                                  logic [WIDTH-1:0] n);
    logic [2*WIDTH-1:0] prod;
    logic [2*WIDTH-1:0] rem;
    prod = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
    if (n == '0) return prod[WIDTH-1:0];
    rem = prod % {{WIDTH{1'b0}}, n};
    return rem[WIDTH-1:0];
  endfunction

  // left-to-right square and multiply from the top set bit
  function automatic logic [WIDTH-1:0] power_reduce(logic [WIDTH-1:0] base, logic [WIDTH-1:0] e,
                                                    logic [WIDTH-1:0] n);
    logic [WIDTH-1:0] acc;
    bit               seen;
    acc  = WIDTH'(1);
    seen = 1'b0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (e[i]) seen = 1'b1;
      if (seen) begin
        acc = mul_reduce(acc, acc, n);
        if (e[i]) acc = mul_reduce(acc, base, n);
      end
    end
    return acc;
  endfunction

  function automatic logic [WIDTH-1:0] predict_chunk(logic act, logic start,
                                                     logic [WIDTH-1:0] data);
    logic [WIDTH-1:0] res;
    if (start) whiten_ctr = whiten_key;
    if (act == ACT_DECRYPT) res = power_reduce(data ^ whiten_ctr, exp_priv, mod_n);
    else res = power_reduce(data, exp_pub, mod_n) ^ whiten_ctr;
    whiten_ctr = whiten_ctr + WIDTH'(1);
    return res;
  endfunction

  task automatic write_cfg(input cfg_reg_t idx, input logic [WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODULUS:    mod_n      = value;
      CFG_PUB_EXP:    exp_pub    = value;
      CFG_PRIV_EXP:   exp_priv   = value;
      CFG_WHITEN_KEY: whiten_key = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all_cfg(input logic [WIDTH-1:0] n, input logic [WIDTH-1:0] e,
                               input logic [WIDTH-1:0] d, input logic [WIDTH-1:0] k);
    write_cfg(CFG_MODULUS, n);
    write_cfg(CFG_PUB_EXP, e);
    write_cfg(CFG_PRIV_EXP, d);
    write_cfg(CFG_WHITEN_KEY, k);
  endtask

  task automatic send_chunk(input logic act, input logic start, input logic [WIDTH-1:0] data);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.start_message <= start;
    in_ch.data_word     <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_chunk(act, start, data));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // registers untouched since reset
  task automatic test_reset_state();
    send_chunk(ACT_ENCRYPT, 1'b0, rand_word());
    send_chunk(ACT_DECRYPT, 1'b0, rand_word());
    drain_results();
  endtask

  // zero exponent gives one, unreduced even for modulus one
  task automatic test_zero_exponent();
    write_all_cfg(64'd1, '0, '0, rand_word());
    send_chunk(ACT_ENCRYPT, 1'b1, rand_word());
    send_chunk(ACT_DECRYPT, 1'b0, rand_word());
    drain_results();
    write_cfg(CFG_MODULUS, '0);
    send_chunk(ACT_ENCRYPT, 1'b0, '1);
    drain_results();
  endtask

  task automatic test_modulus_edges();
    write_all_cfg('0, rand_word(), rand_word(), rand_word());
    send_chunk(ACT_ENCRYPT, 1'b1, rand_word());
    send_chunk(ACT_DECRYPT, 1'b0, rand_word());
    drain_results();
    write_all_cfg(64'd1, 64'd5, 64'd7, '0);
    send_chunk(ACT_ENCRYPT, 1'b1, rand_word());
    send_chunk(ACT_DECRYPT, 1'b0, rand_word());
    drain_results();
  endtask

  // base at or above the modulus, which the core reduces first
  task automatic test_large_base();
    write_all_cfg(64'd1000003, 64'h0000_0000_0001_0001, 64'd3, 64'd0);
    send_chunk(ACT_ENCRYPT, 1'b1, '1);
    send_chunk(ACT_DECRYPT, 1'b0, 64'd1000003);
    drain_results();
  endtask

  task automatic test_field_extremes();
    write_all_cfg('1, '1, '1, '1);
    send_chunk(ACT_ENCRYPT, 1'b1, '0);
    send_chunk(ACT_ENCRYPT, 1'b0, '1);
    send_chunk(ACT_DECRYPT, 1'b1, '1);
    send_chunk(ACT_DECRYPT, 1'b0, '0);
    drain_results();
  endtask

  task automatic test_counter_wrap();
    write_all_cfg(rand_word(), 64'd3, 64'd2, '1);
    send_chunk(ACT_ENCRYPT, 1'b1, rand_word());
    send_chunk(ACT_ENCRYPT, 1'b0, rand_word());
    send_chunk(ACT_DECRYPT, 1'b0, rand_word());
    drain_results();
  endtask

  // small textbook key, encrypt then decrypt the ciphertext back
  task automatic test_round_trip();
    logic [WIDTH-1:0] ct;
    write_all_cfg(64'd3233, 64'd17, 64'd2753, 64'h5a5a_0f0f_3c3c_a5a5);
    send_chunk(ACT_ENCRYPT, 1'b1, 64'd65);
    drain_results();
    ct = predict_chunk(ACT_ENCRYPT, 1'b1, 64'd65);
    send_chunk(ACT_DECRYPT, 1'b1, ct);
    send_chunk(ACT_ENCRYPT, 1'b0, 64'd3232);
    drain_results();
  endtask

  // receiver holds off long enough for the core to fill and stall its input
  task automatic test_output_backpressure();
    bit saved_gaps;
    saved_gaps = tx_gaps_on;
    tx_gaps_on = 1'b0;
    write_all_cfg(rand_word(), {32'd0, $urandom}, {48'd0, 16'($urandom)}, rand_word());
    rx_hold_req = 30000;
    send_chunk(ACT_ENCRYPT, 1'b1, rand_word());
    send_chunk(ACT_DECRYPT, 1'b0, rand_word());
    send_chunk(ACT_ENCRYPT, 1'b0, rand_word());
    drain_results();
    tx_gaps_on = saved_gaps;
  endtask

  // messages of random length, with some stray start flags
  task automatic test_random_messages(input int phases, input int items_per_phase);
    int  msg_left;
    logic start;
    logic act;
    for (int p = 0; p < phases; p++) begin
      case (p % 5)
        0: write_all_cfg(rand_word(), rand_word(), rand_word(), rand_word());
        1: write_all_cfg({48'd0, 16'($urandom)}, {56'd0, 8'($urandom)},
                         {56'd0, 8'($urandom)}, rand_word());
        2: write_all_cfg(rand_word() | {1'b1, {(WIDTH-1){1'b0}}}, rand_word(),
                         {32'd0, $urandom}, rand_word());
        3: write_all_cfg(rand_word() >> $urandom_range(0, 48), {32'd0, $urandom},
                         rand_word(), rand_word());
        default: write_all_cfg(rand_word(), rand_word() >> $urandom_range(0, 60),
                               rand_word() >> $urandom_range(0, 60),
                               '1 - $urandom_range(0, 4));
      endcase
      tx_gaps_on   = (p % 5) != 3;
      rx_stalls_on = (p % 5) != 3;
      msg_left = 0;
      act      = ACT_ENCRYPT;
      for (int i = 0; i < items_per_phase; i++) begin
        start = 1'b0;
        if (msg_left == 0) begin
          start    = 1'b1;
          msg_left = $urandom_range(1, 6);
          act      = logic'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 9) == 0) begin
          start = logic'($urandom_range(0, 1));
          act   = logic'($urandom_range(0, 1));
        end
        send_chunk(act, start, rand_word());
        msg_left--;
      end
      drain_results();
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // receiver side with random stalls and a requested long hold
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
        stall_left = pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time,
                 out_ch.result_word);
        err_cnt++;
      end else begin
        if (out_ch.result_word !== pending_results[0]) begin
          $display("%0t: result_word mismatch, expected %h, actual %h", $time,
                   pending_results[0], out_ch.result_word);
          err_cnt++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    err_cnt      = 0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    rx_hold_req  = 0;
    mod_n        = '0;
    exp_pub      = '0;
    exp_priv     = '0;
    whiten_key   = '0;
    whiten_ctr   = '0;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_MODULUS;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.action        <= ACT_ENCRYPT;
    in_ch.start_message <= 1'b0;
    in_ch.data_word     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_zero_exponent();
    test_modulus_edges();
    test_large_base();
    test_field_extremes();
    test_counter_wrap();
    test_round_trip();
    test_output_backpressure();
    test_random_messages(5, 16);

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rme_pkg.sv
rtl/rme_in_if.sv
rtl/rme_out_if.sv
rtl/rme_modmul.sv
rtl/rsa_modexp_with_counter_whitening_core.sv
verif/tb.sv
